FILE: rtl/grp_pkg.sv
// ----------------------------------------------------------------------------
// grp_pkg
// Shared types and character codes for the geometry record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package grp_pkg;

   localparam int unsigned FIELD_COUNT = 4;
   localparam int unsigned VALUE_W     = 32;

   localparam logic [7:0] CHAR_BAR        = 8'h7C;  // '|'
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;  // '_'
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_ZERO       = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE       = 8'h39;  // '9'
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_LF         = 8'h0A;

   localparam logic [35:0] LIMIT_S32_POS = 36'h0_7FFF_FFFF;
   localparam logic [35:0] LIMIT_S32_NEG = 36'h0_8000_0000;
   localparam logic [35:0] LIMIT_U32     = 36'h0_FFFF_FFFF;

   // Where in the record text we are.
   typedef enum logic [1:0] {
      PHASE_LEAD,
      PHASE_BODY,
      PHASE_TRAIL
   } phase_type;

   // Where in the current field we are.
   typedef enum logic [1:0] {
      POS_START,
      POS_SIGN,
      POS_DIGIT
   } field_pos_type;

endpackage

`default_nettype wire

FILE: rtl/grp_req_if.sv
// ----------------------------------------------------------------------------
// grp_req_if
// Byte channel into the geometry record parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface grp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;

   modport source (output valid, output data_byte, output byte_valid, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_valid, input last,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/grp_rsp_if.sv
// ----------------------------------------------------------------------------
// grp_rsp_if
// Result channel out of the geometry record parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface grp_rsp_if;
   logic               valid;
   logic               ready;
   logic               present;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [31:0]        size_w;
   logic [31:0]        size_h;

   modport source (output valid, output present, output pos_x, output pos_y,
                   output size_w, output size_h, input ready);
   modport sink   (input valid, input present, input pos_x, input pos_y,
                   input size_w, input size_h, output ready);
endinterface

`default_nettype wire

FILE: rtl/geometry_record_parser_core.sv
// ----------------------------------------------------------------------------
// geometry_record_parser_core
// Parses the text record "x|y|width|height" one byte per item.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result register lets it,
// with no bubbles between items: the parse state is updated in the cycle the
// item is accepted, and the item that carries last writes the result register,
// so the result shows up in the cycle after the final item. Only the result
// register sets the pace: a new item is taken whenever that register is empty
// or is being drained in the same cycle; a waiting result stalls the input.
// Rules: blanks (space, tab, CR, LF) are allowed only before and after the
// record text; four fields separated by '|'; each field is an optional '+' or
// '-' then decimal digits with '_' allowed between digits. x and y are signed
// 32-bit, width and height unsigned 32-bit and nonzero ("-0" parses, then
// fails as zero). A failing record gives present=0 and all values zero. After
// each result the parser is back in its reset state, ready for the next record.
// ----------------------------------------------------------------------------
`default_nettype none

module geometry_record_parser_core
   import grp_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   grp_req_if.sink     req_chan,
   grp_rsp_if.source   rsp_chan
);

   // parse state
   logic [1:0]         fld_ff,  fld_in;     // field index 0..3
   phase_type          phase_ff, phase_in;
   logic               neg_ff,  neg_in;     // field had a '-' sign
   field_pos_type      pos_ff,  pos_in;
   logic               pu_ff,   pu_in;      // previous byte was '_'
   logic [31:0]        acc_ff,  acc_in;     // field magnitude
   logic               fail_ff, fail_in;
   logic [31:0]        held_ff [0:FIELD_COUNT-2];
   logic [31:0]        held_in [0:FIELD_COUNT-2];

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               present_ff,   present_in;
   logic [31:0]        x_ff, x_in;
   logic [31:0]        y_ff, y_in;
   logic [31:0]        w_ff, w_in;
   logic [31:0]        h_ff, h_in;

   logic               accept;
   logic               do_content;
   logic               blank;
   logic [7:0]         c;
   logic [35:0]        next_acc;
   logic [35:0]        limit;
   logic               fin_fail;

   // A field may close when it ended in a digit; size fields must also be
   // nonzero and unsigned.
   function automatic logic close_ok(input logic is_size, input field_pos_type p,
                                     input logic u, input logic [31:0] a,
                                     input logic n);
      logic ok;
      ok = (p == POS_DIGIT) && !u;
      if (is_size) begin
         ok = ok && (a != 32'd0) && !n;
      end
      return ok;
   endfunction

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign c              = req_chan.data_byte;

   // acc*10 + digit, never beyond 36 bits
   assign next_acc = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {32'd0, c[3:0]};

   always_comb begin
      fld_in     = fld_ff;
      phase_in   = phase_ff;
      neg_in     = neg_ff;
      pos_in     = pos_ff;
      pu_in      = pu_ff;
      acc_in     = acc_ff;
      fail_in    = fail_ff;
      held_in    = held_ff;
      do_content = 1'b0;
      blank      = c inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};
      limit      = (fld_ff[1] == 1'b0) ? (neg_ff ? LIMIT_S32_NEG : LIMIT_S32_POS)
                                       : LIMIT_U32;

      // blank trimming, then the byte itself
      if (accept && req_chan.byte_valid && !fail_ff) begin
         case (phase_ff)
            PHASE_LEAD: begin
               if (!blank) begin
                  phase_in   = PHASE_BODY;
                  do_content = 1'b1;
               end
            end
            PHASE_BODY: begin
               if (blank) begin
                  phase_in = PHASE_TRAIL;
               end else begin
                  do_content = 1'b1;
               end
            end
            PHASE_TRAIL: begin
               if (!blank) begin
                  fail_in = 1'b1;
               end
            end
            default: begin
               fail_in = 1'b1;
            end
         endcase
      end

      if (do_content) begin
         if (c == CHAR_BAR) begin
            if (fld_ff == 2'(FIELD_COUNT - 1) ||
                !close_ok(fld_ff[1], pos_ff, pu_ff, acc_ff, neg_ff)) begin
               fail_in = 1'b1;
            end else begin
               // x and y are stored two's complement
               held_in[fld_ff] = (neg_ff && !fld_ff[1]) ? (32'd0 - acc_ff) : acc_ff;
               fld_in = fld_ff + 2'd1;
               neg_in = 1'b0;
               pos_in = POS_START;
               pu_in  = 1'b0;
               acc_in = 32'd0;
            end
         end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            if (pos_ff != POS_START) begin
               fail_in = 1'b1;
            end else begin
               neg_in = (c == CHAR_MINUS);
               pos_in = POS_SIGN;
            end
         end else if (c == CHAR_UNDERSCORE) begin
            if (pos_ff != POS_DIGIT) begin
               fail_in = 1'b1;
            end else begin
               pu_in = 1'b1;
            end
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (next_acc > limit) begin
               fail_in = 1'b1;
            end else begin
               acc_in = next_acc[31:0];
               pos_in = POS_DIGIT;
               pu_in  = 1'b0;
            end
         end else begin
            fail_in = 1'b1;
         end
      end

      // end of record: close the height field and check the field count
      fin_fail = fail_in || (phase_in == PHASE_LEAD) || (fld_in != 2'(FIELD_COUNT - 1))
              || !close_ok(1'b1, pos_in, pu_in, acc_in, neg_in);

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      present_in   = present_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      w_in         = w_ff;
      h_in         = h_ff;

      if (accept && req_chan.last) begin
         rsp_valid_in = 1'b1;
         present_in   = !fin_fail;
         x_in         = fin_fail ? 32'd0 : held_in[0];
         y_in         = fin_fail ? 32'd0 : held_in[1];
         w_in         = fin_fail ? 32'd0 : held_in[2];
         h_in         = fin_fail ? 32'd0 : acc_in;
         // back to reset state for the next record
         fld_in   = 2'd0;
         phase_in = PHASE_LEAD;
         neg_in   = 1'b0;
         pos_in   = POS_START;
         pu_in    = 1'b0;
         acc_in   = 32'd0;
         fail_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fld_ff       <= 2'd0;
         phase_ff     <= PHASE_LEAD;
         neg_ff       <= 1'b0;
         pos_ff       <= POS_START;
         pu_ff        <= 1'b0;
         acc_ff       <= 32'd0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fld_ff       <= fld_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         pos_ff       <= pos_in;
         pu_ff        <= pu_in;
         acc_ff       <= acc_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      held_ff    <= held_in;
      present_ff <= present_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      w_ff       <= w_in;
      h_ff       <= h_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.present = present_ff;
   assign rsp_chan.pos_x   = signed'(x_ff);
   assign rsp_chan.pos_y   = signed'(y_ff);
   assign rsp_chan.size_w  = w_ff;
   assign rsp_chan.size_h  = h_ff;

endmodule

`default_nettype wire

FILE: tb/sv/geometry_record_parser_core_tb.sv
// ----------------------------------------------------------------------------
// geometry_record_parser_core_tb
// Self-checking bench for the geometry record parser. Record text is fed one
// byte item at a time, mixed with empty items, bare end markers, random idle
// cycles on both channels and one long result stall. A behavioral parser in
// the bench predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module geometry_record_parser_core_tb
   import grp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 1780;  // counted-item total, all tests together, that ends the random part
   localparam int unsigned HOLD_CYCLES  = 250;   // length of the forced result stall
   localparam int unsigned IDLE_PCT     = 23;    // idle chance per cycle, both sides
   localparam int unsigned DRAIN_CYCLES = 16;    // settle time after the last result
   localparam int unsigned MAX_REPORTS  = 10;

   // How a record is closed off on the byte channel.
   typedef enum logic [1:0] {
      END_ON_BYTE,   // last rides on the final text byte
      END_BARE,      // separate item with byte_valid=0, last=1
      END_OPEN       // no end yet, caller goes on with the record
   } record_end_type;

   typedef logic [7:0] text_type[$];

   typedef struct packed {
      logic               present;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        size_w;
      logic [31:0]        size_h;
   } geometry_type;

   logic clock;
   logic reset;

   grp_req_if req_chan ();
   grp_rsp_if rsp_chan ();

   geometry_record_parser_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Results predicted but not yet seen on the result channel, oldest first.
   geometry_type pending_geometry[$];

   int unsigned mismatch_count = 0;
   int unsigned counted_items  = 0;  // items carrying a byte or an end marker
   bit          quiet_mode     = 1'b0;  // no random idling on either side
   bit          hold_request   = 1'b0;  // ask the result side for a long stall

   // -------------------------------------------------------------------------
   // Parser prediction state
   // -------------------------------------------------------------------------
   phase_type     text_phase;
   field_pos_type field_pos;
   logic [2:0]    field_idx;
   logic          field_neg;
   logic          after_usc;
   logic          rec_failed;
   logic [32:0]   magnitude;
   logic [31:0]   field_value[FIELD_COUNT];

   function automatic logic is_blank(logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;
   endfunction

   task automatic clear_field();
      field_neg = 1'b0;
      field_pos = POS_START;
      after_usc = 1'b0;
      magnitude = '0;
   endtask

   task automatic clear_parser();
      field_idx  = '0;
      text_phase = PHASE_LEAD;
      rec_failed = 1'b0;
      clear_field();
      foreach (field_value[k]) field_value[k] = '0;
   endtask

   // Close the current field and keep its value; any rule broken fails the record.
   task automatic close_field();
      logic [1:0] k;
      k = field_idx[1:0];
      if (field_pos != POS_DIGIT || after_usc)
         rec_failed = 1'b1;
      else if (k < 2)
         field_value[k] = field_neg ? 32'd0 - magnitude[31:0] : magnitude[31:0];
      else if (magnitude == '0 || field_neg)
         rec_failed = 1'b1;   // sizes must be nonzero and unsigned; -0 lands here
      else
         field_value[k] = magnitude[31:0];
   endtask

   task automatic parse_text(logic [7:0] c);
      logic [35:0] limit;
      logic [35:0] next_mag;
      if (c == CHAR_BAR) begin
         if (field_idx >= FIELD_COUNT - 1) begin
            rec_failed = 1'b1;   // fifth field
         end else begin
            close_field();
            if (!rec_failed) begin
               field_idx++;
               clear_field();
            end
         end
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         if (field_pos != POS_START) begin
            rec_failed = 1'b1;
         end else begin
            field_neg = (c == CHAR_MINUS);
            field_pos = POS_SIGN;
         end
      end else if (c == CHAR_UNDERSCORE) begin
         if (field_pos != POS_DIGIT) rec_failed = 1'b1;
         else after_usc = 1'b1;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         if (field_idx < 2) limit = field_neg ? LIMIT_S32_NEG : LIMIT_S32_POS;
         else limit = LIMIT_U32;
         next_mag = {3'b000, magnitude} * 36'd10 + {28'd0, c - CHAR_ZERO};
         if (next_mag > limit) begin
            rec_failed = 1'b1;   // overflow fails at the offending digit
         end else begin
            magnitude = next_mag[32:0];
            field_pos = POS_DIGIT;
            after_usc = 1'b0;
         end
      end else begin
         rec_failed = 1'b1;
      end
   endtask

   task automatic parse_byte(logic [7:0] c);
      if (rec_failed) return;   // rest of a failed record is dropped
      case (text_phase)
         PHASE_LEAD: begin
            if (!is_blank(c)) begin
               text_phase = PHASE_BODY;
               parse_text(c);
            end
         end
         PHASE_BODY: begin
            if (is_blank(c)) text_phase = PHASE_TRAIL;
            else parse_text(c);
         end
         default: begin
            if (!is_blank(c)) rec_failed = 1'b1;
         end
      endcase
   endtask

   // Apply one accepted item; on last, queue the expected geometry and restart.
   task automatic predict_parse(logic [7:0] c, logic has_byte, logic is_last);
      geometry_type g;
      if (has_byte) parse_byte(c);
      if (is_last) begin
         if (!rec_failed) begin
            if (text_phase == PHASE_LEAD || field_idx != FIELD_COUNT - 1)
               rec_failed = 1'b1;
            else
               close_field();
         end
         g.present = !rec_failed;
         g.pos_x   = rec_failed ? '0 : field_value[0];
         g.pos_y   = rec_failed ? '0 : field_value[1];
         g.size_w  = rec_failed ? '0 : field_value[2];
         g.size_h  = rec_failed ? '0 : field_value[3];
         pending_geometry.push_back(g);
         clear_parser();
      end
   endtask

   // -------------------------------------------------------------------------
   // Clock, limit
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Result side: random ready, quiet stretches, and one long hold-off
   // -------------------------------------------------------------------------
   initial begin : result_sink
      int unsigned stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------
   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   initial begin : result_check
      geometry_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_geometry.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t result with none expected: present=%b x=%h y=%h w=%h h=%h",
                           $realtime, rsp_chan.present, rsp_chan.pos_x, rsp_chan.pos_y,
                           rsp_chan.size_w, rsp_chan.size_h);
            end else begin
               want = pending_geometry.pop_front();
               if (rsp_chan.present !== want.present)
                  note_mismatch("present", 32'(want.present), 32'(rsp_chan.present));
               if (rsp_chan.pos_x !== want.pos_x)
                  note_mismatch("pos_x", want.pos_x, rsp_chan.pos_x);
               if (rsp_chan.pos_y !== want.pos_y)
                  note_mismatch("pos_y", want.pos_y, rsp_chan.pos_y);
               if (rsp_chan.size_w !== want.size_w)
                  note_mismatch("size_w", want.size_w, rsp_chan.size_w);
               if (rsp_chan.size_h !== want.size_h)
                  note_mismatch("size_h", want.size_h, rsp_chan.size_h);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Byte channel driving
   // -------------------------------------------------------------------------
   // Offer one item, with random idle cycles ahead of it, and hold it until the
   // block takes it. The payload is scrambled while valid is low.
   task automatic send_item(logic [7:0] c, logic has_byte, logic is_last);
      if (!quiet_mode) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_chan.valid      <= 1'b0;
            req_chan.data_byte  <= 8'($urandom);
            req_chan.byte_valid <= 1'($urandom);
            req_chan.last       <= 1'($urandom);
            @(posedge clock);
         end
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= c;
      req_chan.byte_valid <= has_byte;
      req_chan.last       <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      if (has_byte || is_last) counted_items++;
      predict_parse(c, has_byte, is_last);
   endtask

   // Send a record text; optionally sprinkle empty items (no byte, no last).
   task automatic send_record(text_type text, record_end_type how, bit sprinkle);
      for (int i = 0; i < text.size(); i++) begin
         if (sprinkle && $urandom_range(99) < 10) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(text[i], 1'b1, how == END_ON_BYTE && i == text.size() - 1);
      end
      if (how == END_BARE || (how == END_ON_BYTE && text.size() == 0))
         send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   function automatic text_type to_text(string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   // -------------------------------------------------------------------------
   // Random record builder
   // -------------------------------------------------------------------------
   function automatic logic [7:0] blank_char();
      case ($urandom_range(3))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // One field: optional sign, a magnitude biased toward the limits, and some
   // leading zeros or underscores, now and then in illegal spots.
   function automatic void append_field(ref text_type t, input int idx);
      longint unsigned mag;
      longint unsigned lim;
      logic [7:0]      digits[$];
      bit              neg;
      bit              with_usc;
      int unsigned     pick;
      pick = $urandom_range(99);
      neg  = 1'b0;
      if (idx < 2) begin
         if (pick < 15) begin
            t.push_back(CHAR_MINUS);
            neg = 1'b1;
         end else if (pick < 30) begin
            t.push_back(CHAR_PLUS);
         end
      end else begin
         if (pick < 5) begin
            t.push_back(CHAR_MINUS);
            neg = 1'b1;
         end else if (pick < 15) begin
            t.push_back(CHAR_PLUS);
         end
      end
      if ($urandom_range(99) < 2) t.push_back(CHAR_UNDERSCORE);
      if (idx < 2) lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      else lim = 64'hFFFF_FFFF;
      pick = $urandom_range(99);
      if (pick < 40)      mag = $urandom_range(999);
      else if (pick < 60) mag = $urandom;
      else if (pick < 85) mag = lim - 3 + $urandom_range(6);   // straddle the limit
      else if (pick < 95) mag = 0;
      else                mag = {$urandom, $urandom};           // far too many digits
      if ($urandom_range(99) < 10) repeat ($urandom_range(1, 2)) t.push_back(CHAR_ZERO);
      do begin
         digits.push_front(CHAR_ZERO + 8'(mag % 10));
         mag = mag / 10;
      end while (mag != 0);
      with_usc = $urandom_range(99) < 20;
      for (int i = 0; i < digits.size(); i++) begin
         t.push_back(digits[i]);
         if (with_usc && i < digits.size() - 1 && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) t.push_back(CHAR_UNDERSCORE);
      end
      if ($urandom_range(99) < 3) t.push_back(CHAR_UNDERSCORE);
   endfunction

   function automatic text_type random_record();
      text_type    t;
      int unsigned pick;
      int unsigned nfields;
      int unsigned at;
      pick = $urandom_range(99);
      if (pick < 4) begin
         // pure noise
         repeat ($urandom_range(1, 12)) t.push_back(8'($urandom));
         return t;
      end
      if (pick < 7) begin
         // blanks only, possibly nothing at all
         repeat ($urandom_range(3)) t.push_back(blank_char());
         return t;
      end
      nfields = ($urandom_range(99) < 8) ? $urandom_range(1, 6) : FIELD_COUNT;
      if ($urandom_range(99) < 30) repeat ($urandom_range(1, 3)) t.push_back(blank_char());
      for (int f = 0; f < nfields; f++) begin
         if (f > 0) t.push_back(CHAR_BAR);
         append_field(t, (f < FIELD_COUNT) ? f : FIELD_COUNT - 1);
      end
      if ($urandom_range(99) < 30) repeat ($urandom_range(1, 3)) t.push_back(blank_char());
      // one local corruption in a fifth of the records
      if ($urandom_range(99) < 20) begin
         at = $urandom_range(t.size() - 1);
         case ($urandom_range(3))
            0:       t[at] = 8'($urandom);
            1:       t.insert(at, 8'($urandom));
            2:       t.insert(at, blank_char());
            default: t.delete(at);
         endcase
      end
      return t;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // Smallest x, largest y and width, smallest legal height; last on a byte.
   task automatic test_field_extremes();
      send_record(to_text("-2147483648|2147483647|4294967295|1"), END_ON_BYTE, 1'b0);
   endtask

   task automatic test_special_cases();
      // empty record: a bare end marker and nothing else
      send_record(to_text(""), END_BARE, 1'b0);
      // blanks at both ends, plus sign, run of underscores, an empty item
      // inside the record and a bare end marker
      send_record(to_text("\t 0|+0|"), END_OPEN, 1'b0);
      send_item(8'hA5, 1'b0, 1'b0);
      send_record(to_text("1__0|9\r\n"), END_BARE, 1'b0);
      // -0 as width fails; the bytes after it are dropped
      send_record(to_text("1|2|-0|3"), END_ON_BYTE, 1'b0);
      // blank inside the record
      send_record(to_text("1 |2|3|4"), END_ON_BYTE, 1'b0);
   endtask

   // A result is held behind a long stall while the byte side keeps offering.
   task automatic test_backpressure();
      quiet_mode   = 1'b1;
      hold_request = 1'b1;
      repeat (6) send_record(to_text("12|-3|4|5"), END_ON_BYTE, 1'b0);
      quiet_mode = 1'b0;
   endtask

   task automatic test_random_records();
      int unsigned rec_num;
      rec_num = 0;
      while (counted_items < RANDOM_ITEMS) begin
         // a stretch of records with no idling on either side
         quiet_mode = (rec_num >= 20 && rec_num < 40);
         send_record(random_record(), ($urandom_range(99) < 30) ? END_BARE : END_ON_BYTE,
                     1'b1);
         rec_num++;
      end
      quiet_mode = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= '0;
      req_chan.byte_valid <= 1'b0;
      req_chan.last       <= 1'b0;
      clear_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_special_cases();
      test_backpressure();
      test_random_records();

      req_chan.valid <= 1'b0;
      while (pending_geometry.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_geometry.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/grp_pkg.sv
rtl/grp_req_if.sv
rtl/grp_rsp_if.sv
rtl/geometry_record_parser_core.sv
tb/sv/geometry_record_parser_core_tb.sv
